// ===== hdl/pcts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Punzi cut scan package
// Shared widths, the job record passed from loader to scanner, state types.
// ----------------------------------------------------------------------------
package pcts_pkg;

   localparam int BINS   = 64;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int W_W    = 32;
   localparam int SUM_W  = 38;
   localparam int Q_W    = 17;
   localparam int FRAC_W = 16;
   localparam int NUM_W  = SUM_W + Q_W;
   localparam int RAD_W  = SUM_W + FRAC_W;
   localparam int ROOT_W = RAD_W / 2;
   localparam int D_W    = ROOT_W + 1;
   localparam int ONE_Q12 = 4096;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sig_total;
      logic [SUM_W-1:0] bg_total;
   } job_type;

   typedef enum logic {
      FR_LOAD,
      FR_WAIT
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_READ,
      BK_ACC,
      BK_EL_GO,
      BK_EL_WT,
      BK_EU_GO,
      BK_EU_WT,
      BK_SL_GO,
      BK_SL_WT,
      BK_SU_GO,
      BK_SU_WT,
      BK_ML_GO,
      BK_ML_WT,
      BK_MU_GO,
      BK_MU_WT,
      BK_OUT
   } back_state_type;

endpackage
`default_nettype wire

// ===== hdl/punzi_cut_threshold_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Punzi cut threshold scan
// Loads a signal/background histogram and scans lower and upper cuts.
// ----------------------------------------------------------------------------
// Usage: the req_ channel takes one histogram bin per beat, at most one beat
// per cycle while loading. Bins beyond 64 are dropped. The beat with
// req_last_bin set closes the histogram and hands a job to the scan engine;
// req_ready then stays low until the last result of the scan has been loaded
// into the output register.
// The rsp_ channel gives one beat per stored bin, in bin order; the last beat
// carries rsp_final_res and the two best-cut indices.
// Each result runs a store read, an accumulate, four divisions (start, 17
// quotient bits, done) and two square roots (start, 27 root bits, done), one
// after another on a single divider and a single root unit, and an output
// step.
// A stalled receiver holds the result register; the engine waits with the
// next result finished until the held beat is taken.
// Reset empties the histogram and aborts any scan; the bin store itself is
// not cleared, as only bins written since are ever read.
// ----------------------------------------------------------------------------
module punzi_cut_threshold_scan (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [pcts_pkg::W_W-1:0]     req_sig_weight,
   input  wire logic [pcts_pkg::W_W-1:0]     req_bg_weight,
   input  wire logic                         req_last_bin,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [pcts_pkg::IDX_W-1:0]        rsp_bin_index,
   output logic [pcts_pkg::Q_W-1:0]          rsp_eff_lower,
   output logic [pcts_pkg::Q_W-1:0]          rsp_merit_lower,
   output logic [pcts_pkg::Q_W-1:0]          rsp_eff_upper,
   output logic [pcts_pkg::Q_W-1:0]          rsp_merit_upper,
   output logic [pcts_pkg::IDX_W-1:0]        rsp_best_lower,
   output logic [pcts_pkg::IDX_W-1:0]        rsp_best_upper,
   output logic                              rsp_final_res
);
   import pcts_pkg::*;

   job_type          job;
   logic             job_valid, job_take, scan_done, rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [W_W-1:0]   rd_sig, rd_bg;

   pcts_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sig_weight (req_sig_weight),
      .req_bg_weight  (req_bg_weight),
      .req_last_bin   (req_last_bin),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_sig         (rd_sig),
      .rd_bg          (rd_bg),
      .job            (job),
      .job_valid      (job_valid),
      .job_take       (job_take),
      .scan_done      (scan_done)
   );

   pcts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job             (job),
      .job_valid       (job_valid),
      .job_take        (job_take),
      .scan_done       (scan_done),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_sig          (rd_sig),
      .rd_bg           (rd_bg),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_eff_lower   (rsp_eff_lower),
      .rsp_merit_lower (rsp_merit_lower),
      .rsp_eff_upper   (rsp_eff_upper),
      .rsp_merit_upper (rsp_merit_upper),
      .rsp_best_lower  (rsp_best_lower),
      .rsp_best_upper  (rsp_best_upper),
      .rsp_final_res   (rsp_final_res)
   );

endmodule
`default_nettype wire

// ===== hdl/pcts_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Punzi cut scan loader
// Accepts histogram beats, stores the bins, keeps totals and queues a job.
// ----------------------------------------------------------------------------
module pcts_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [pcts_pkg::W_W-1:0] req_sig_weight,
   input  wire logic [pcts_pkg::W_W-1:0] req_bg_weight,
   input  wire logic                     req_last_bin,
   input  wire logic                     rd_en,
   input  wire logic [pcts_pkg::IDX_W-1:0] rd_addr,
   output logic [pcts_pkg::W_W-1:0]      rd_sig,
   output logic [pcts_pkg::W_W-1:0]      rd_bg,
   output pcts_pkg::job_type             job,
   output logic                          job_valid,
   input  wire logic                     job_take,
   input  wire logic                     scan_done
);
   import pcts_pkg::*;

   logic [W_W-1:0] sig_mem [BINS];
   logic [W_W-1:0] bg_mem [BINS];

   front_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sig_tot_ff, sig_tot_in, bg_tot_ff, bg_tot_in;
   job_type          job_ff;
   logic             job_valid_ff;
   logic             accept, room;

   assign accept = req_valid & req_ready;
   assign room   = cnt_ff < CNT_W'(BINS);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_LOAD: if (accept && req_last_bin) state_in = FR_WAIT;
         FR_WAIT: if (scan_done) state_in = FR_LOAD;
         default: state_in = FR_LOAD;
      endcase
   end

   always_comb begin
      case (state_ff)
         FR_LOAD: req_ready = ~job_valid_ff;
         default: req_ready = 1'b0;
      endcase
   end

   always_comb begin
      cnt_in     = cnt_ff;
      sig_tot_in = sig_tot_ff;
      bg_tot_in  = bg_tot_ff;
      if (room) begin
         cnt_in     = cnt_ff + 1'b1;
         sig_tot_in = sig_tot_ff + SUM_W'(req_sig_weight);
         bg_tot_in  = bg_tot_ff + SUM_W'(req_bg_weight);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FR_LOAD;
         cnt_ff       <= '0;
         sig_tot_ff   <= '0;
         bg_tot_ff    <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (job_take) job_valid_ff <= 1'b0;
         if (accept) begin
            if (req_last_bin) begin
               cnt_ff       <= '0;
               sig_tot_ff   <= '0;
               bg_tot_ff    <= '0;
               job_valid_ff <= 1'b1;
            end else begin
               cnt_ff     <= cnt_in;
               sig_tot_ff <= sig_tot_in;
               bg_tot_ff  <= bg_tot_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_bin) begin
         job_ff.count     <= cnt_in;
         job_ff.sig_total <= sig_tot_in;
         job_ff.bg_total  <= bg_tot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         sig_mem[cnt_ff[IDX_W-1:0]] <= req_sig_weight;
         bg_mem[cnt_ff[IDX_W-1:0]]  <= req_bg_weight;
      end
      if (rd_en) begin
         rd_sig <= sig_mem[rd_addr];
         rd_bg  <= bg_mem[rd_addr];
      end
   end

   assign job       = job_ff;
   assign job_valid = job_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/pcts_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Punzi cut scan divider
// Restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits.
// ----------------------------------------------------------------------------
module pcts_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pcts_pkg::NUM_W-1:0] num,
   input  wire logic [pcts_pkg::SUM_W-1:0] den,
   output logic                            done,
   output logic [pcts_pkg::Q_W-1:0]        quo
);
   import pcts_pkg::*;
   localparam int STEP_W = $clog2(Q_W);

   logic [SUM_W-1:0]  rem_ff, rem_in, den_ff;
   logic [Q_W-1:0]    low_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff, done_ff;
   logic [SUM_W:0]    rem_sh, diff;
   logic              ge;

   assign rem_sh = {rem_ff, low_ff[Q_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_in = ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(Q_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num[NUM_W-1:Q_W];
         low_ff <= num[Q_W-1:0];
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[Q_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = low_ff;

endmodule
`default_nettype wire

// ===== hdl/pcts_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Punzi cut scan square root
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pcts_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pcts_pkg::RAD_W-1:0]  rad,
   output logic                             done,
   output logic [pcts_pkg::ROOT_W-1:0]      root
);
   import pcts_pkg::*;
   localparam int REM_W  = ROOT_W + 2;
   localparam int STEP_W = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff, done_ff;
   logic [REM_W+1:0]  rem_sh, trial, diff;
   logic              ge;

   assign rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = (REM_W + 2)'({root_ff, 2'b01});
   assign diff   = rem_sh - trial;
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= rad;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (run_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         root_ff <= {root_ff[ROOT_W-2:0], ge};
         rem_ff  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== hdl/pcts_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Punzi cut scan engine
// Walks the stored bins of a job and produces one result beat per bin.
// ----------------------------------------------------------------------------
module pcts_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pcts_pkg::job_type            job,
   input  wire logic                         job_valid,
   output logic                              job_take,
   output logic                              scan_done,
   output logic                              rd_en,
   output logic [pcts_pkg::IDX_W-1:0]        rd_addr,
   input  wire logic [pcts_pkg::W_W-1:0]     rd_sig,
   input  wire logic [pcts_pkg::W_W-1:0]     rd_bg,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [pcts_pkg::IDX_W-1:0]        rsp_bin_index,
   output logic [pcts_pkg::Q_W-1:0]          rsp_eff_lower,
   output logic [pcts_pkg::Q_W-1:0]          rsp_merit_lower,
   output logic [pcts_pkg::Q_W-1:0]          rsp_eff_upper,
   output logic [pcts_pkg::Q_W-1:0]          rsp_merit_upper,
   output logic [pcts_pkg::IDX_W-1:0]        rsp_best_lower,
   output logic [pcts_pkg::IDX_W-1:0]        rsp_best_upper,
   output logic                              rsp_final_res
);
   import pcts_pkg::*;

   back_state_type state_ff, state_in;
   job_type          job_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [SUM_W-1:0] sig_pre_ff, bg_pre_ff, sig_up_ff, bg_up_ff;
   logic [Q_W-1:0]   el_ff, eu_ff, ml_ff, mu_ff, max_lo_ff, max_hi_ff;
   logic [ROOT_W-1:0] r_lo_ff, r_hi_ff;
   logic [IDX_W-1:0] best_lo_ff, best_hi_ff, best_lo_nx, best_hi_nx;
   logic             rsp_valid_ff;
   logic             out_free, is_last;

   logic             div_start, div_done, sq_start, sq_done;
   logic [NUM_W-1:0] div_num;
   logic [SUM_W-1:0] div_den;
   logic [Q_W-1:0]   div_q;
   logic [RAD_W-1:0] sq_rad;
   logic [ROOT_W-1:0] sq_root;
   logic [D_W-1:0]   d_sel;

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign is_last  = {1'b0, idx_ff} == job_ff.count - 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (job_valid) state_in = BK_READ;
         BK_READ:  state_in = BK_ACC;
         BK_ACC:   state_in = BK_EL_GO;
         BK_EL_GO: state_in = BK_EL_WT;
         BK_EL_WT: if (div_done) state_in = BK_EU_GO;
         BK_EU_GO: state_in = BK_EU_WT;
         BK_EU_WT: if (div_done) state_in = BK_SL_GO;
         BK_SL_GO: state_in = BK_SL_WT;
         BK_SL_WT: if (sq_done) state_in = BK_SU_GO;
         BK_SU_GO: state_in = BK_SU_WT;
         BK_SU_WT: if (sq_done) state_in = BK_ML_GO;
         BK_ML_GO: state_in = BK_ML_WT;
         BK_ML_WT: if (div_done) state_in = BK_MU_GO;
         BK_MU_GO: state_in = BK_MU_WT;
         BK_MU_WT: if (div_done) state_in = BK_OUT;
         BK_OUT:   if (out_free) state_in = is_last ? BK_IDLE : BK_READ;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_take  = 1'b0;
      scan_done = 1'b0;
      rd_en     = 1'b0;
      div_start = 1'b0;
      sq_start  = 1'b0;
      case (state_ff)
         BK_IDLE:  job_take  = job_valid;
         BK_READ:  rd_en     = 1'b1;
         BK_EL_GO, BK_EU_GO, BK_ML_GO, BK_MU_GO: div_start = 1'b1;
         BK_SL_GO, BK_SU_GO: sq_start = 1'b1;
         BK_OUT:   scan_done = out_free & is_last;
         default:  job_take  = 1'b0;
      endcase
   end

   assign rd_addr = idx_ff;

   // Divider operands: efficiencies use the signal total, merits use 16 + sqrt(B) in Q.8.
   always_comb begin
      d_sel   = (state_ff == BK_MU_GO) ? D_W'(ONE_Q12) + D_W'(r_hi_ff)
                                       : D_W'(ONE_Q12) + D_W'(r_lo_ff);
      div_num = NUM_W'({sig_pre_ff, {FRAC_W{1'b0}}}) + NUM_W'(job_ff.sig_total >> 1);
      div_den = job_ff.sig_total;
      case (state_ff)
         BK_EU_GO: div_num = NUM_W'({sig_up_ff, {FRAC_W{1'b0}}})
                             + NUM_W'(job_ff.sig_total >> 1);
         BK_ML_GO: begin
            div_num = NUM_W'({el_ff, 12'b0}) + NUM_W'(d_sel >> 1);
            div_den = SUM_W'(d_sel);
         end
         BK_MU_GO: begin
            div_num = NUM_W'({eu_ff, 12'b0}) + NUM_W'(d_sel >> 1);
            div_den = SUM_W'(d_sel);
         end
         default: div_den = job_ff.sig_total;
      endcase
      sq_rad = (state_ff == BK_SU_GO) ? {bg_up_ff, {FRAC_W{1'b0}}}
                                      : {bg_pre_ff, {FRAC_W{1'b0}}};
   end

   pcts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q)
   );

   pcts_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .rad   (sq_rad),
      .done  (sq_done),
      .root  (sq_root)
   );

   // First maximum wins, so only a strictly larger merit moves the best index.
   assign best_lo_nx = (ml_ff > max_lo_ff) ? idx_ff : best_lo_ff;
   assign best_hi_nx = (mu_ff > max_hi_ff) ? idx_ff : best_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            job_ff     <= job;
            idx_ff     <= '0;
            sig_pre_ff <= '0;
            bg_pre_ff  <= '0;
            max_lo_ff  <= '0;
            max_hi_ff  <= '0;
            best_lo_ff <= '0;
            best_hi_ff <= '0;
         end
         BK_ACC: begin
            sig_up_ff  <= job_ff.sig_total - sig_pre_ff;
            bg_up_ff   <= job_ff.bg_total - bg_pre_ff;
            sig_pre_ff <= sig_pre_ff + SUM_W'(rd_sig);
            bg_pre_ff  <= bg_pre_ff + SUM_W'(rd_bg);
         end
         BK_EL_WT: if (div_done) el_ff <= (job_ff.sig_total == '0) ? '0 : div_q;
         BK_EU_WT: if (div_done) eu_ff <= (job_ff.sig_total == '0) ? '0 : div_q;
         BK_SL_WT: if (sq_done) r_lo_ff <= sq_root;
         BK_SU_WT: if (sq_done) r_hi_ff <= sq_root;
         BK_ML_WT: if (div_done) ml_ff <= div_q;
         BK_MU_WT: if (div_done) mu_ff <= div_q;
         BK_OUT: begin
            if (out_free) begin
               rsp_bin_index   <= idx_ff;
               rsp_eff_lower   <= el_ff;
               rsp_merit_lower <= ml_ff;
               rsp_eff_upper   <= eu_ff;
               rsp_merit_upper <= mu_ff;
               rsp_best_lower  <= is_last ? best_lo_nx : '0;
               rsp_best_upper  <= is_last ? best_hi_nx : '0;
               rsp_final_res   <= is_last;
               best_lo_ff      <= best_lo_nx;
               best_hi_ff      <= best_hi_nx;
               if (ml_ff > max_lo_ff) max_lo_ff <= ml_ff;
               if (mu_ff > max_hi_ff) max_hi_ff <= mu_ff;
               idx_ff          <= idx_ff + 1'b1;
            end
         end
         default: idx_ff <= idx_ff;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== verif/pcts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Punzi cut scan checker
// Watches both channels, predicts every result beat of each scan from the
// accepted bin beats, and compares the result beats field by field in order.
// ----------------------------------------------------------------------------
module pcts_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic [pcts_pkg::W_W-1:0]     req_sig_weight,
   input  wire logic [pcts_pkg::W_W-1:0]     req_bg_weight,
   input  wire logic                         req_last_bin,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [pcts_pkg::IDX_W-1:0]   rsp_bin_index,
   input  wire logic [pcts_pkg::Q_W-1:0]     rsp_eff_lower,
   input  wire logic [pcts_pkg::Q_W-1:0]     rsp_merit_lower,
   input  wire logic [pcts_pkg::Q_W-1:0]     rsp_eff_upper,
   input  wire logic [pcts_pkg::Q_W-1:0]     rsp_merit_upper,
   input  wire logic [pcts_pkg::IDX_W-1:0]   rsp_best_lower,
   input  wire logic [pcts_pkg::IDX_W-1:0]   rsp_best_upper,
   input  wire logic                         rsp_final_res,
   output int                                fail_count,
   output int                                pending
);
   import pcts_pkg::*;

   typedef struct {
      logic [IDX_W-1:0] bin_index;
      logic [Q_W-1:0]   eff_lower;
      logic [Q_W-1:0]   merit_lower;
      logic [Q_W-1:0]   eff_upper;
      logic [Q_W-1:0]   merit_upper;
      logic [IDX_W-1:0] best_lower;
      logic [IDX_W-1:0] best_upper;
      logic             final_res;
   } scan_result_type;

   scan_result_type  scan_queue[$];
   logic [W_W-1:0]   sig_bins[BINS];
   logic [W_W-1:0]   bg_bins[BINS];
   int               loaded;
   logic [SUM_W-1:0] sig_sum;
   logic [SUM_W-1:0] bg_sum;

   initial fail_count = 0;
   assign pending = scan_queue.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic logic [63:0] int_root(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [Q_W-1:0] fraction_q16(input logic [63:0] part,
                                                    input logic [63:0] total);
      if (total == 0) return 0;
      return Q_W'(((part << 16) + (total >> 1)) / total);
   endfunction

   function automatic logic [Q_W-1:0] punzi(input logic [Q_W-1:0] eff,
                                             input logic [63:0] bg);
      logic [63:0] d;
      if (eff == 0) return 0;
      d = ONE_Q12 + int_root(bg << 16);
      return Q_W'(((64'(eff) << 12) + (d >> 1)) / d);
   endfunction

   task automatic predict_scan();
      logic [63:0]  sig_pre;
      logic [63:0]  bg_pre;
      logic [63:0]  sig_up;
      logic [63:0]  bg_up;
      logic [Q_W-1:0] max_lo;
      logic [Q_W-1:0] max_hi;
      int           best_lo;
      int           best_hi;
      scan_result_type r;
      sig_pre = 0;
      bg_pre = 0;
      max_lo = 0;
      max_hi = 0;
      best_lo = 0;
      best_hi = 0;
      for (int i = 0; i < loaded; i++) begin
         sig_up = sig_sum - sig_pre;
         bg_up = bg_sum - bg_pre;
         sig_pre += sig_bins[i];
         bg_pre += bg_bins[i];
         r.bin_index = IDX_W'(i);
         r.eff_lower = fraction_q16(sig_pre, sig_sum);
         r.eff_upper = fraction_q16(sig_up, sig_sum);
         r.merit_lower = punzi(r.eff_lower, bg_pre);
         r.merit_upper = punzi(r.eff_upper, bg_up);
         if (r.merit_lower > max_lo) begin
            max_lo = r.merit_lower;
            best_lo = i;
         end
         if (r.merit_upper > max_hi) begin
            max_hi = r.merit_upper;
            best_hi = i;
         end
         r.best_lower = 0;
         r.best_upper = 0;
         r.final_res = 0;
         if (i == loaded - 1) begin
            r.best_lower = IDX_W'(best_lo);
            r.best_upper = IDX_W'(best_hi);
            r.final_res = 1'b1;
         end
         scan_queue = {scan_queue, r};
      end
      loaded = 0;
      sig_sum = 0;
      bg_sum = 0;
   endtask

   always @(posedge clock) begin
      scan_result_type w;
      if (reset) begin
         loaded = 0;
         sig_sum = 0;
         bg_sum = 0;
      end else begin
         if (req_valid && req_ready) begin
            // Bins beyond a full store are dropped, but a closing beat still scans.
            if (loaded < BINS) begin
               sig_bins[loaded] = req_sig_weight;
               bg_bins[loaded] = req_bg_weight;
               sig_sum += req_sig_weight;
               bg_sum += req_bg_weight;
               loaded++;
            end
            if (req_last_bin) predict_scan();
         end
         if (rsp_valid && rsp_ready) begin
            if (scan_queue.size() == 0) begin
               report("unexpected result beat", rsp_bin_index, -1);
            end else begin
               w = scan_queue.pop_front();
               if (rsp_bin_index !== w.bin_index)
                  report("bin_index", rsp_bin_index, w.bin_index);
               if (rsp_eff_lower !== w.eff_lower)
                  report("eff_lower", rsp_eff_lower, w.eff_lower);
               if (rsp_merit_lower !== w.merit_lower)
                  report("merit_lower", rsp_merit_lower, w.merit_lower);
               if (rsp_eff_upper !== w.eff_upper)
                  report("eff_upper", rsp_eff_upper, w.eff_upper);
               if (rsp_merit_upper !== w.merit_upper)
                  report("merit_upper", rsp_merit_upper, w.merit_upper);
               if (rsp_best_lower !== w.best_lower)
                  report("best_lower", rsp_best_lower, w.best_lower);
               if (rsp_best_upper !== w.best_upper)
                  report("best_upper", rsp_best_upper, w.best_upper);
               if (rsp_final_res !== w.final_res)
                  report("final_res", rsp_final_res, w.final_res);
            end
         end
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Punzi cut scan testbench
// Drives histograms of assorted sizes and weights with random idling on both
// channels; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
   import pcts_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [W_W-1:0]   req_sig_weight;
   logic [W_W-1:0]   req_bg_weight;
   logic             req_last_bin;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [IDX_W-1:0] rsp_bin_index;
   logic [Q_W-1:0]   rsp_eff_lower;
   logic [Q_W-1:0]   rsp_merit_lower;
   logic [Q_W-1:0]   rsp_eff_upper;
   logic [Q_W-1:0]   rsp_merit_upper;
   logic [IDX_W-1:0] rsp_best_lower;
   logic [IDX_W-1:0] rsp_best_upper;
   logic             rsp_final_res;
   int               fail_count;
   int               pending;

   bit               quiet;
   bit               hold_req;
   int               bins_sent;

   typedef enum int {
      WT_RANDOM,
      WT_SMALL,
      WT_ZERO,
      WT_MAX,
      WT_MIXED
   } weight_mode_type;

   punzi_cut_threshold_scan i_dut (.*);

   pcts_checker i_checker (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [W_W-1:0] pick_weight(input weight_mode_type m);
      case (m)
         WT_RANDOM: return $urandom;
         WT_SMALL:  return $urandom_range(0, 300);
         WT_ZERO:   return 0;
         WT_MAX:    return '1;
         default: begin
            case ($urandom_range(0, 4))
               0: return 0;
               1: return '1;
               2: return $urandom_range(0, 255);
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   task automatic send_bin(input logic [W_W-1:0] s, input logic [W_W-1:0] b,
                           input logic last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sig_weight <= s;
      req_bg_weight <= b;
      req_last_bin <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bins_sent++;
   endtask

   task automatic send_hist(input int n, input weight_mode_type sm,
                            input weight_mode_type bm);
      for (int i = 0; i < n; i++)
         send_bin(pick_weight(sm), pick_weight(bm), i == n - 1);
   endtask

   // The checker queues a scan at the closing edge, so wait for the next edge before polling pending.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int n;
      quiet = 1'b0;
      hold_req = 1'b0;
      bins_sent = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sig_weight <= '0;
      req_bg_weight <= '0;
      req_last_bin <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, a single-bin histogram, zero signal, ties.
      send_bin('1, '1, 1'b0);
      send_bin(0, 0, 1'b1);
      send_bin('1, 0, 1'b1);
      send_bin(0, '1, 1'b0);
      send_bin(0, 5, 1'b0);
      send_bin(0, 0, 1'b1);
      send_bin(256, 0, 1'b0);
      send_bin(256, 0, 1'b0);
      send_bin(256, 0, 1'b1);
      send_bin(1, '1, 1'b0);
      send_bin('1, 1, 1'b0);
      send_bin(32'h8000_0000, 32'h0000_0100, 1'b1);
      send_bin(0, 0, 1'b0);
      send_bin(0, 0, 1'b1);
      wait_drained();

      // Random histograms, mostly small, some filling or overflowing the store.
      while (bins_sent < 265) begin
         if (bins_sent > 80 && bins_sent < 90) begin
            hold_req = 1'b1;
            send_hist(6, WT_RANDOM, WT_SMALL);
            send_hist(5, WT_MIXED, WT_MIXED);
         end
         if ($urandom_range(0, 25) == 0) begin
            n = $urandom_range(0, 1) ? BINS : BINS + 3;
            send_hist(n, WT_MIXED, WT_MIXED);
         end else begin
            n = $urandom_range(1, 8);
            case ($urandom_range(0, 9))
               0: send_hist(n, WT_ZERO, WT_MIXED);
               1: send_hist(n, WT_MAX, WT_MAX);
               2: send_hist(n, WT_SMALL, WT_SMALL);
               3: send_hist(n, WT_MIXED, WT_ZERO);
               4, 5: send_hist(n, WT_RANDOM, WT_RANDOM);
               default: send_hist(n, WT_MIXED, WT_MIXED);
            endcase
         end
         if (bins_sent > 160 && bins_sent < 175) wait_drained();
         if (bins_sent > 240) quiet = 1'b1;
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/pcts_pkg.sv
hdl/pcts_front.sv
hdl/pcts_div.sv
hdl/pcts_sqrt.sv
hdl/pcts_back.sv
hdl/punzi_cut_threshold_scan.sv
verif/pcts_checker.sv
verif/testbench.sv
